### rtl/core/itoa_pkg.sv
// Shared types and constants for the integer-to-ASCII formatter.
package itoa_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int IN_VALUE_W     = 64;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_A_LC  = 8'h61;
    localparam logic [7:0] ASCII_MINUS = 8'h2d;
    localparam logic [3:0] DEC_BASE    = 4'd10;
    localparam logic [3:0] DABBLE_MIN  = 4'd5;
    localparam logic [3:0] DABBLE_ADD  = 4'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD_DEC,
        OP_LOAD_HEX,
        OP_DABBLE,
        OP_SHIFT
    } t_dab_op;

    typedef struct packed {
        t_dab_op op;
    } t_dab_cmd;

    typedef struct packed {
        logic       conv_done;
        logic       last_digit;
        logic [3:0] top_digit;
    } t_dab_stat;

    typedef struct packed {
        logic       push;
        logic       is_sign;
        logic [3:0] digit;
        logic       last;
    } t_char_req;

    typedef struct packed {
        logic [IN_VALUE_W-1:0] value;
        logic                  hex_mode;
        logic                  signed_mode;
    } t_in_item;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_out_item;

endpackage

### rtl/core/itoa_dabble.sv
// Digit register with shared shift/add-3 step for binary to BCD; hex digits load directly.
module itoa_dabble
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int NUM_DIGITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dab_cmd              i_cmd,
    input  logic [VALUE_BITS-1:0] i_value,
    output t_dab_stat             o_stat
);

    localparam int BW = NUM_DIGITS * 4;
    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam int LW = $clog2(NUM_DIGITS + 1);

    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic [BW-1:0]         r_bcd, n_bcd;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [LW-1:0]         r_len, n_len;
    logic [BW-1:0]         w_adj;

    // add 3 to every digit of five or more before the shift
    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_adj
        assign w_adj[4*g +: 4] = (r_bcd[4*g +: 4] >= DABBLE_MIN) ?
                                 r_bcd[4*g +: 4] + DABBLE_ADD : r_bcd[4*g +: 4];
    end

    always_comb begin
        n_mag = r_mag;
        n_bcd = r_bcd;
        n_cnt = r_cnt;
        n_len = r_len;
        case (i_cmd.op)
            OP_LOAD_DEC: begin
                n_mag = i_value;
                n_bcd = '0;
                n_cnt = CW'(VALUE_BITS);
                n_len = LW'(NUM_DIGITS);
            end
            OP_LOAD_HEX: begin
                n_bcd = BW'(i_value);
                n_cnt = '0;
                n_len = LW'(NUM_DIGITS);
            end
            OP_DABBLE: begin
                n_bcd = {w_adj[BW-2:0], r_mag[VALUE_BITS-1]};
                n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
            end
            OP_SHIFT: begin
                n_bcd = {r_bcd[BW-5:0], 4'd0};
                n_len = r_len - 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_len <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_len <= n_len;
        end
        r_mag <= n_mag;
        r_bcd <= n_bcd;
    end

    assign o_stat.conv_done  = (r_cnt == '0);
    assign o_stat.last_digit = (r_len == LW'(1));
    assign o_stat.top_digit  = r_bcd[BW-1 -: 4];

endmodule

### rtl/core/itoa_outreg.sv
// ASCII encoder and output register of the result channel.
module itoa_outreg
    import itoa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_char_req i_req,
    output logic      o_space,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic       r_valid;
    t_out_item  r_data;
    logic [7:0] w_char;

    always_comb begin
        if (i_req.is_sign) begin
            w_char = ASCII_MINUS;
        end else if (i_req.digit < DEC_BASE) begin
            w_char = ASCII_ZERO + {4'd0, i_req.digit};
        end else begin
            w_char = ASCII_A_LC + {4'd0, i_req.digit - DEC_BASE};
        end
    end

    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_req.push;
        end
        if (o_space && i_req.push) begin
            r_data.character <= w_char;
            r_data.last      <= i_req.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/core/integer_to_ascii_formatter.sv
// Top level of the integer-to-ASCII formatter: sequencer, sign handling, port glue.
//
// Usage: an input request carries a value, a hex/decimal select and a signed flag.
// The block answers with the value's ASCII text, one character per output
// request, most significant digit first, with last set on the final character.
// Hex uses lower-case a-f; zero prints as '0'; a negative signed decimal value
// prints '-' and its magnitude, the most negative value as 2^(VALUE_BITS-1).
// Both channels are valid/ready. o_ready is high only while the sequencer is
// idle; one number is worked at a time.
// Sequence without stalls, with D = number of digit positions (20 for 64 bits):
//   decimal: a load, VALUE_BITS double-dabble steps, a done check,
//            (D - digits) zero skips, a skip exit, then the minus sign if any
//            and one character per cycle;
//   hex:     a load, (D - digits) zero skips, a skip exit, then one character
//            per cycle.
// The decimal path adds the shared add-3/shift step over the digit register.
// The first character appears in the cycle after the sequencer pushes it into the
// output register. If the receiver stalls, the output register holds its
// character and the sequencer waits; nothing is lost or repeated.
// Reset (synchronous, active low) returns to idle and empties the output stage.
module integer_to_ascii_formatter
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    // decimal digits of 2^VALUE_BITS - 1 (1233/4096 ~ log10 2)
    localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;

    t_state    r_state, n_state;
    logic      r_neg, n_neg;
    logic      r_hex, n_hex;
    t_dab_cmd  w_cmd;
    t_dab_stat w_stat;
    t_char_req w_req;
    logic      w_space;

    logic [VALUE_BITS-1:0] w_raw;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_neg_in;

    // take the sign off at load; negating the most negative value gives 2^(n-1)
    assign w_raw    = i_data.value[VALUE_BITS-1:0];
    assign w_neg_in = i_data.signed_mode && !i_data.hex_mode && w_raw[VALUE_BITS-1];
    assign w_mag    = w_neg_in ? VALUE_BITS'(~w_raw + 1'b1) : w_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_neg   <= 1'b0;
            r_hex   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_neg   <= n_neg;
            r_hex   <= n_hex;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_neg         = r_neg;
        n_hex         = r_hex;
        w_cmd.op      = OP_HOLD;
        w_req.push    = 1'b0;
        w_req.is_sign = 1'b0;
        w_req.digit   = w_stat.top_digit;
        w_req.last    = w_stat.last_digit;
        o_ready       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_neg    = w_neg_in;
                    n_hex    = i_data.hex_mode;
                    w_cmd.op = i_data.hex_mode ? OP_LOAD_HEX : OP_LOAD_DEC;
                    n_state  = i_data.hex_mode ? S_SKIP : S_CONV;
                end
            end
            S_CONV: begin
                // one add-3/shift step per cycle until all bits are in
                if (w_stat.conv_done) begin
                    n_state = S_SKIP;
                end else begin
                    w_cmd.op = OP_DABBLE;
                end
            end
            S_SKIP: begin
                // drop leading zeros, keep at least one digit
                if (w_stat.top_digit == 4'd0 && !w_stat.last_digit) begin
                    w_cmd.op = OP_SHIFT;
                end else begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (w_space) begin
                    w_req.push    = 1'b1;
                    w_req.is_sign = 1'b1;
                    w_req.last    = 1'b0;
                    n_state       = S_EMIT;
                end
            end
            S_EMIT: begin
                // advance one digit per accepted slot in the output register
                if (w_space) begin
                    w_req.push = 1'b1;
                    w_cmd.op   = OP_SHIFT;
                    if (w_stat.last_digit) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    itoa_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_value (w_mag),
        .o_stat  (w_stat)
    );

    itoa_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_space (w_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // a minus sign is never the final character
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.character == ASCII_MINUS) |-> !o_data.last)
        else $error("minus sign marked as last character");

    // decimal conversion leaves only digits 0-9
    a_dec_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_hex) |-> (w_stat.top_digit <= 4'd9))
        else $error("decimal digit out of range");

    // pushing the final digit returns the sequencer to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_req.push && w_stat.last_digit) |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after last digit");

endmodule

### tb/sv/tb_integer_to_ascii_formatter.sv
// Self-checking testbench for the integer-to-ASCII formatter: directed edges, random traffic, stalls.
module tb_integer_to_ascii_formatter;
    import itoa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          VALUE_BITS   = VALUE_BITS_DEF;
    localparam int          CLK_HALF_NS  = 4;
    localparam int          RESET_CYCLES = 11;
    // Worst item: its conversion plus 20 characters, each possibly held by a busy
    // receiver. Several hundred items fit far below this.
    localparam int          LIMIT_CYCLES = 400000;
    localparam int          TAIL_CYCLES  = 150;
    localparam logic        RADIX_DEC    = 1'b0;
    localparam logic        RADIX_HEX    = 1'b1;
    localparam logic        AS_UNSIGNED  = 1'b0;
    localparam logic        AS_SIGNED    = 1'b1;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;

    // Characters still owed by the block, oldest first.
    t_out_item pending_chars[$];

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned rx_hold_left;
    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned numbers_sent;
    int unsigned chars_checked;
    int unsigned negatives_sent;
    int unsigned hex_sent;

    integer_to_ascii_formatter #(
        .VALUE_BITS(VALUE_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // Build the text that one request must produce and queue it character by
    // character. Digits are peeled off least significant first, so prepend.
    function automatic void predict_text(input t_in_item req);
        logic [VALUE_BITS-1:0] mag;
        logic [VALUE_BITS-1:0] digit;
        logic [7:0]            text[$];
        logic                  negative;
        logic [VALUE_BITS-1:0] radix;
        t_out_item             ch;
        mag      = req.value[VALUE_BITS-1:0];
        radix    = (req.hex_mode == RADIX_HEX) ? VALUE_BITS'(16) : VALUE_BITS'(10);
        // Sign only matters in decimal; hex always prints the raw pattern.
        negative = (req.signed_mode == AS_SIGNED) && (req.hex_mode == RADIX_DEC)
                   && mag[VALUE_BITS-1];
        // Negating the most negative value leaves 2^(N-1), which is the wanted magnitude.
        if (negative) begin
            mag = -mag;
        end
        do begin
            digit = mag % radix;
            if (digit < 10) begin
                text.push_front(ASCII_ZERO + digit[7:0]);
            end else begin
                text.push_front(ASCII_A_LC + digit[7:0] - 8'd10);
            end
            mag = mag / radix;
        end while (mag != 0);
        if (negative) begin
            text.push_front(ASCII_MINUS);
            negatives_sent++;
        end
        foreach (text[i]) begin
            ch.character = text[i];
            ch.last      = (i == text.size() - 1);
            pending_chars.push_back(ch);
        end
    endfunction

    function automatic t_in_item make_item(input logic [63:0] value, input logic hex,
                                           input logic sgn);
        t_in_item req;
        req.value       = value;
        req.hex_mode    = hex;
        req.signed_mode = sgn;
        return req;
    endfunction

    // Pick a number from one of several shapes so short, long, negative and
    // boundary texts all show up often.
    function automatic t_in_item random_number();
        logic [63:0] v;
        logic [31:0] w;
        logic [63:0] p;
        int unsigned n;
        case ($urandom_range(7))
            0, 7: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(300));
            2: begin
                w = $urandom;
                v = {{32{w[31]}}, w};
            end
            3: v = {$urandom, $urandom} >> $urandom_range(63);
            4: v = -64'($urandom_range(1, 1000));
            5: begin
                p = ($urandom_range(1) == 0) ? 64'd10 : 64'd16;
                n = $urandom_range(1, 19);
                v = 64'd1;
                repeat (n) v = v * p;
                v = v + 64'($urandom_range(2)) - 64'd1;
            end
            default: v = ~({$urandom, $urandom} >> $urandom_range(63));
        endcase
        return make_item(v, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    // Offer one request, optionally after an idle gap, and predict its text
    // once the block takes it. Valid is left high so back-to-back requests
    // need no second assignment in the same step.
    task automatic send_number(input t_in_item req);
        int unsigned gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 110) : $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        do @(posedge i_clk); while (!o_ready);
        predict_text(req);
        numbers_sent++;
        if (req.hex_mode == RADIX_HEX) begin
            hex_sent++;
        end
    endtask

    // Drop valid and hold until every owed character has come out.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_extremes();
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        send_number(make_item(64'd0, RADIX_DEC, AS_UNSIGNED));
        send_number(make_item(64'd0, RADIX_HEX, AS_UNSIGNED));
        send_number(make_item(64'd0, RADIX_DEC, AS_SIGNED));
        send_number(make_item(64'd9, RADIX_DEC, AS_UNSIGNED));
        send_number(make_item(64'd10, RADIX_DEC, AS_SIGNED));
        send_number(make_item(64'd15, RADIX_HEX, AS_UNSIGNED));
        send_number(make_item(64'd16, RADIX_HEX, AS_UNSIGNED));
        // All ones: twenty decimal digits, sixteen hex digits, or minus one.
        send_number(make_item(64'hFFFF_FFFF_FFFF_FFFF, RADIX_DEC, AS_UNSIGNED));
        send_number(make_item(64'hFFFF_FFFF_FFFF_FFFF, RADIX_HEX, AS_UNSIGNED));
        send_number(make_item(64'hFFFF_FFFF_FFFF_FFFF, RADIX_DEC, AS_SIGNED));
        // Most negative value and its neighbors.
        send_number(make_item(64'h8000_0000_0000_0000, RADIX_DEC, AS_SIGNED));
        send_number(make_item(64'h8000_0000_0000_0000, RADIX_DEC, AS_UNSIGNED));
        send_number(make_item(64'h8000_0000_0000_0000, RADIX_HEX, AS_SIGNED));
        send_number(make_item(64'h7FFF_FFFF_FFFF_FFFF, RADIX_DEC, AS_SIGNED));
        send_number(make_item(64'h8000_0000_0000_0001, RADIX_DEC, AS_SIGNED));
        // Every hex letter, and signed flag ignored in hex.
        send_number(make_item(64'h0123_4567_89AB_CDEF, RADIX_HEX, AS_UNSIGNED));
        send_number(make_item(64'hFEDC_BA98_7654_3210, RADIX_HEX, AS_SIGNED));
        // Top power of ten and the largest nineteen-digit number.
        send_number(make_item(64'd10000000000000000000, RADIX_DEC, AS_UNSIGNED));
        send_number(make_item(64'd9999999999999999999, RADIX_DEC, AS_UNSIGNED));
        send_number(make_item(64'hFFFF_FFFF_FFFF_FFF6, RADIX_DEC, AS_SIGNED));
        // 32-bit values as a caller would extend them.
        send_number(make_item(64'hFFFF_FFFF_8000_0000, RADIX_DEC, AS_SIGNED));
        send_number(make_item(64'h0000_0000_FFFF_FFFF, RADIX_DEC, AS_UNSIGNED));
        send_number(make_item(64'd1, RADIX_DEC, AS_SIGNED));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned count, input int unsigned tx_pct,
                                       input int unsigned rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) send_number(random_number());
    endtask

    // Hold the receiver off for a long stretch while long texts keep coming,
    // so the output register fills and the block refuses new requests.
    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        rx_hold_left = 400;
        repeat (4) send_number(make_item({$urandom, $urandom} | 64'h8000_0000_0000_0000,
                                         RADIX_DEC, AS_UNSIGNED));
        repeat (4) send_number(random_number());
    endtask

    // Pause the sender until the block is fully drained, then resume.
    task automatic test_drain_pause();
        tx_idle_pct = 10;
        rx_idle_pct = 10;
        repeat (5) send_number(random_number());
        wait_drained();
        repeat (5) send_number(random_number());
        wait_drained();
    endtask

    // Receiver: long hold-off when asked, otherwise random back-pressure.
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_left != 0) begin
                i_ready <= 1'b0;
                rx_hold_left--;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Compare each accepted character with the oldest one owed.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected character 0x%02h last=%0b", o_data.character, o_data.last);
                mismatch_count++;
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (o_data.character !== want.character) begin
                    $error("character: expected 0x%02h, got 0x%02h",
                           want.character, o_data.character);
                    mismatch_count++;
                end
                if (o_data.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_data.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run if the block hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        rx_hold_left   = 0;
        mismatch_count = 0;
        numbers_sent   = 0;
        chars_checked  = 0;
        negatives_sent = 0;
        hex_sent       = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_random_traffic(100, 6, 73);
        test_random_traffic(100, 73, 6);
        test_random_traffic(100, 0, 0);
        test_output_backpressure();
        test_drain_pause();

        // Let any stray extra characters surface before judging.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d numbers (%0d hex, %0d negative decimal), %0d characters checked",
                 numbers_sent, hex_sent, negatives_sent, chars_checked);
        $display("with receiver and sender stalls, a long output hold-off and a full drain");
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
